// ===== rtl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg: shared definitions for the Base64 encoder
// Character codes, queue sizing, the job record and the alphabet lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] CHAR_UPPER = 8'h41;
	localparam logic [7:0] CHAR_LOWER = 8'h61;
	localparam logic [7:0] CHAR_DIGIT = 8'h30;
	localparam logic [7:0] CHAR_D62   = 8'h2D;
	localparam logic [7:0] CHAR_D63   = 8'h7E;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] PH_0 = 2'd0;
	localparam logic [1:0] PH_1 = 2'd1;
	localparam logic [1:0] PH_2 = 2'd2;

	typedef struct packed {
		logic [1:0]      last_idx;
		logic            last;
		logic [3:0]      pad;
		logic [3:0][5:0] digit;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] v8;
		logic [7:0] ch;
		v8 = {2'b00, v};
		if (v < 6'd26) begin
			ch = CHAR_UPPER + v8;
		end else if (v < 6'd52) begin
			ch = CHAR_LOWER + v8 - 8'd26;
		end else if (v < 6'd62) begin
			ch = CHAR_DIGIT + v8 - 8'd52;
		end else if (v == 6'd62) begin
			ch = CHAR_D62;
		end else begin
			ch = CHAR_D63;
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front: byte intake and group tracking
// Accepts bytes, keeps the group phase and leftover bits, and builds one
// job record per byte that lists the characters it produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64e_front import b64e_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	input  wire logic       q_full,
	output logic            push,
	output job_t            push_job
);

	logic [1:0] phase_q;
	logic [3:0] carry_q;
	logic [1:0] phase_nxt;
	logic [3:0] carry_nxt;

	assign push = in_valid && !q_full;

	always_comb begin
		push_job          = '0;
		push_job.last     = final_byte;
		phase_nxt         = PH_0;
		carry_nxt         = 4'd0;
		case (phase_q)
			PH_1: begin
				push_job.digit[0] = {carry_q[1:0], data_byte[7:4]};
				if (final_byte) begin
					push_job.digit[1] = {data_byte[3:0], 2'b00};
					push_job.pad[2]   = 1'b1;
					push_job.last_idx = 2'd2;
				end else begin
					push_job.last_idx = 2'd0;
					phase_nxt         = PH_2;
					carry_nxt         = data_byte[3:0];
				end
			end
			PH_2: begin
				push_job.digit[0] = {carry_q, data_byte[7:6]};
				push_job.digit[1] = data_byte[5:0];
				push_job.last_idx = 2'd1;
			end
			default: begin
				push_job.digit[0] = data_byte[7:2];
				if (final_byte) begin
					push_job.digit[1] = {data_byte[1:0], 4'b0000};
					push_job.pad[2]   = 1'b1;
					push_job.pad[3]   = 1'b1;
					push_job.last_idx = 2'd3;
				end else begin
					push_job.last_idx = 2'd0;
					phase_nxt         = PH_1;
					carry_nxt         = {2'b00, data_byte[1:0]};
				end
			end
		endcase
		if (final_byte) begin
			phase_nxt = PH_0;
			carry_nxt = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_0;
			carry_q <= 4'd0;
		end else if (push) begin
			phase_q <= phase_nxt;
			carry_q <= carry_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue: job queue between intake and character output
// A small circular buffer of job records with full and empty status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue import b64e_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  job_t       push_job,
	input  wire logic  pop,
	output job_t       head_job,
	output q_status_t  status
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back: character output
// Walks the head job's characters into the output register one per cycle
// unless the output stalls, and retires the job after its last character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b64e_back import b64e_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  job_t       head_job,
	input  wire logic  q_empty,
	output logic       pop,
	input  wire logic  out_stall,
	output logic       out_valid,
	output logic [7:0] out_char,
	output logic       last_char
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       last_char_q;
	logic       can_load;
	logic       emit;
	logic       at_end;

	assign can_load = !out_valid_q || !out_stall;
	assign emit     = can_load && !q_empty;
	assign at_end   = (idx_q == head_job.last_idx);
	assign pop      = emit && at_end;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q  <= head_job.pad[idx_q] ? PAD_CHAR : b64_char(head_job.digit[idx_q]);
			last_char_q <= head_job.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_load) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_char_q;

endmodule

`default_nettype wire

// ===== rtl/base64_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_encoder: streaming Base64 encoder
// Turns a byte stream into Base64-style characters, padding the final group.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   data_byte[7:0], final_byte
//  out      output     out_valid / out_stall out_char[7:0], last_char
//
//  A byte is taken in the cycle it arrives while the job queue has room.
//  Characters leave one per cycle from the output register while it is not
//  stalled; three bytes give four characters, a final byte up to four.
//  Reset clears the group phase, the queue and the output valid flag.
//  A stall on the output fills the queue, which then stalls the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module base64_encoder import b64e_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_char,
	output logic            last_char
);

	logic      push;
	job_t      push_job;
	logic      pop;
	job_t      head_job;
	q_status_t status;

	assign in_stall = status.full;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_full     (status.full),
		.push       (push),
		.push_job   (push_job)
	);

	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.status   (status)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.q_empty   (status.empty),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_char  (out_char),
		.last_char (last_char)
	);

	a_status_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(status.full && status.empty))
		else $error("queue reports full and empty at once");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !status.empty)
		else $error("queue empty right after a transaction was queued");

	a_out_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!status.empty))
		else $error("output transaction appeared without a queued job");

	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!status.empty && (!out_valid || !out_stall)))
		else $error("job retired while output register was blocked");

endmodule

`default_nettype wire

// ===== tb/base64_encoder_test.sv =====
// ----------------------------------------------------------------------------
// base64_encoder_test: self-checking testbench for the Base64 encoder
// Drives byte messages through the encoder with random idling on both sides,
// predicts or looks up each output character, checking it as it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_encoder_test import b64e_pkg::*;;

	localparam int CYCLE_LIMIT = 40000;
	localparam int HOLD_CYCLES = 60;
	localparam int TAIL_CYCLES = 20;
	localparam int N_DIRECTED  = 21;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_rec_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        fin;
		logic [2:0]  n_typed;
		logic [31:0] typed;
	} dir_row_t;

	// A row with n_typed of zero is checked against the predictor.
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{8'h00, 1'b1, 3'd4, 32'("AA==")},
		'{8'hFF, 1'b1, 3'd4, 32'("~w==")},
		'{8'h00, 1'b0, 3'd1, 32'("A")},
		'{8'h00, 1'b1, 3'd3, 32'("AA=")},
		'{8'hFF, 1'b0, 3'd1, 32'("~")},
		'{8'hFF, 1'b1, 3'd3, 32'("~8=")},
		'{8'h00, 1'b0, 3'd1, 32'("A")},
		'{8'h00, 1'b0, 3'd1, 32'("A")},
		'{8'h00, 1'b1, 3'd2, 32'("AA")},
		'{8'hFF, 1'b0, 3'd1, 32'("~")},
		'{8'hFF, 1'b0, 3'd1, 32'("~")},
		'{8'hFF, 1'b1, 3'd2, 32'("~~")},
		'{8'h4D, 1'b0, 3'd0, 32'd0},
		'{8'h61, 1'b0, 3'd0, 32'd0},
		'{8'h6E, 1'b0, 3'd0, 32'd0},
		'{8'h4D, 1'b1, 3'd0, 32'd0},
		'{8'hA5, 1'b0, 3'd0, 32'd0},
		'{8'h5A, 1'b0, 3'd0, 32'd0},
		'{8'hC3, 1'b0, 3'd0, 32'd0},
		'{8'h3C, 1'b0, 3'd0, 32'd0},
		'{8'h81, 1'b1, 3'd0, 32'd0}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       final_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_char;
	logic       last_char;

	string      b64_alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-~";
	char_rec_t  pending_chars [$];
	char_rec_t  oldest;
	logic [1:0] grp_pos;
	logic [3:0] leftover;
	logic [7:0] group_chars [4];
	int         group_len;
	int         failures;
	int         cycles;
	int         send_gap_pct;
	int         recv_stall_pct;
	int         hold_left;
	logic       hold_request;
	logic       hold_taken;
	int         bytes_sent;

	base64_encoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.last_char  (last_char)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		return b64_alphabet[v];
	endfunction

	function void predict_byte(input logic [7:0] b, input logic fin);
		case (grp_pos)
		PH_1: begin
			group_chars[0] = sextet_char({leftover[1:0], b[7:4]});
			if (fin) begin
				group_chars[1] = sextet_char({b[3:0], 2'b00});
				group_chars[2] = PAD_CHAR;
				group_len = 3;
			end else begin
				leftover = b[3:0];
				grp_pos = PH_2;
				group_len = 1;
			end
		end
		PH_2: begin
			group_chars[0] = sextet_char({leftover, b[7:6]});
			group_chars[1] = sextet_char(b[5:0]);
			group_len = 2;
			leftover = 4'd0;
			grp_pos = PH_0;
		end
		default: begin
			group_chars[0] = sextet_char(b[7:2]);
			if (fin) begin
				group_chars[1] = sextet_char({b[1:0], 4'b0000});
				group_chars[2] = PAD_CHAR;
				group_chars[3] = PAD_CHAR;
				group_len = 4;
			end else begin
				leftover = {2'b00, b[1:0]};
				grp_pos = PH_1;
				group_len = 1;
			end
		end
		endcase
		if (fin) begin
			grp_pos = PH_0;
			leftover = 4'd0;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin,
			input logic [2:0] n_typed, input logic [31:0] typed);
		int i;
		char_rec_t rec;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_byte(b, fin);
		if (n_typed != 3'd0) begin
			for (i = 0; i < n_typed; i++) begin
				rec.ch = typed[8 * (n_typed - 1 - i) +: 8];
				rec.last = fin && (i == n_typed - 1);
				pending_chars.push_back(rec);
			end
		end else begin
			for (i = 0; i < group_len; i++) begin
				rec.ch = group_chars[i];
				rec.last = fin && (i == group_len - 1);
				pending_chars.push_back(rec);
			end
		end
		bytes_sent++;
	endtask

	task automatic send_messages(input int n_bytes);
		int stop_at;
		int len;
		int k;
		logic [7:0] b;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 7);
			for (k = 0; k < len; k++) begin
				case ($urandom_range(0, 9))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom_range(0, 255));
				endcase
				send_byte(b, k == len - 1, 3'd0, 32'd0);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
			hold_taken = 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_request && !hold_taken) begin
			out_stall <= 1'b1;
			hold_left = HOLD_CYCLES;
			hold_taken = 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected transaction: out_char %h last_char %b", out_char, last_char);
				failures++;
			end else begin
				oldest = pending_chars.pop_front();
				if (out_char !== oldest.ch) begin
					$error("out_char: expected %h, actual %h", oldest.ch, out_char);
					failures++;
				end
				if (last_char !== oldest.last) begin
					$error("last_char: expected %b, actual %b", oldest.last, last_char);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("base64_encoder regression: fail");
			$finish;
		end
	end

	initial begin
		int r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		final_byte = 1'b0;
		grp_pos = PH_0;
		leftover = 4'd0;
		group_len = 0;
		hold_request = 1'b0;
		bytes_sent = 0;
		send_gap_pct = 18;
		recv_stall_pct = 61;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < N_DIRECTED; r++) begin
			send_byte(DIRECTED[r].data, DIRECTED[r].fin, DIRECTED[r].n_typed,
				DIRECTED[r].typed);
		end
		send_messages(28);

		send_gap_pct = 61;
		recv_stall_pct = 18;
		send_messages(28);

		// The long hold fills the job queue while bytes keep arriving.
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		send_messages(27);
		in_valid <= 1'b0;

		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("base64_encoder regression: pass");
		end else begin
			$display("base64_encoder regression: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_encoder.sv
tb/base64_encoder_test.sv
